[rtl/tsmc_pkg.sv]
`default_nettype none

package tsmc_pkg;

  // Fixed-point formats of the datapath
  localparam int FRAC_W   = 30;          // fraction bits of every internal value
  localparam int ANGLE_W  = 31;          // unsigned Q1.30 angle
  localparam int X2_W     = 32;          // x^2 of a clamped angle stays below 2^32
  localparam int RECIP_W  = 31;          // 1/n! in Q.30, at most 2^30
  localparam int TERM_W   = 31;          // every single series term stays below 2^31
  localparam int ACC_W    = 33;          // signed partial sums, well inside +-2^32
  localparam int RESULT_W = 31;          // Q1.30 sine and cosine, 0 .. 2^30
  localparam int DIFF_W   = 32;          // signed Q1.30 difference

  localparam int TERM_COUNT_DEFAULT = 10;
  localparam int TERM_MIN           = 4;
  localparam int TERM_MAX           = 16;

  localparam logic [ANGLE_W-1:0]  HALF_PI = ANGLE_W'(1686629713);
  localparam logic [RESULT_W-1:0] ONE     = RESULT_W'(1) << FRAC_W;

  // round_half_up(2^30 / n!) for n = 0 .. 2*TERM_MAX-1
  localparam logic [RECIP_W-1:0] RECIP [2*TERM_MAX] = '{
    31'd1073741824, 31'd1073741824, 31'd536870912, 31'd178956971,
    31'd44739243,   31'd8947849,    31'd1491308,   31'd213044,
    31'd26631,      31'd2959,       31'd296,       31'd27,
    31'd2,          31'd0,          31'd0,         31'd0,
    31'd0,          31'd0,          31'd0,         31'd0,
    31'd0,          31'd0,          31'd0,         31'd0,
    31'd0,          31'd0,          31'd0,         31'd0,
    31'd0,          31'd0,          31'd0,         31'd0
  };

endpackage

`default_nettype wire

[rtl/taylor_sine_minus_cosine.sv]
`default_nettype none

// Taylor-series sine and cosine of an unsigned Q1.30 angle (clamped to pi/2),
// returned as Q1.30 sine, Q1.30 cosine and their signed difference. The block
// accepts one angle every cycle while in_stall is low and returns one result
// per angle, in order. The front end clamps the angle in a register and then
// squares it with a sliced multiply and rounding add, each of the TERM_COUNT
// series steps is a sliced multiply then a rounding add, and the tail adds the
// last terms in a sum register before the output register. Every product is
// rounded half up at 30 fraction bits and the final sine and cosine sums are
// saturated to [0, 1]. A two-entry output buffer lets the pipeline keep taking
// angles while a result waits; in_stall rises only once that buffer is full.
module taylor_sine_minus_cosine #(
  parameter int TERM_COUNT = tsmc_pkg::TERM_COUNT_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [tsmc_pkg::ANGLE_W-1:0]       angle,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [tsmc_pkg::RESULT_W-1:0]      sine_value,
  output      logic [tsmc_pkg::RESULT_W-1:0]      cosine_value,
  output      logic signed [tsmc_pkg::DIFF_W-1:0] difference
);

  // Width of the power chains: the largest power x^(2*TERM_COUNT-1) at
  // x = pi/2 has about 0.652 integer bits per exponent step, plus margin.
  localparam int POW_W = ((2 * TERM_COUNT - 1) * 652) / 1000 + tsmc_pkg::FRAC_W + 2;

  logic                               advance;
  logic                               front_valid;
  logic [tsmc_pkg::ANGLE_W-1:0]       front_x;
  logic [tsmc_pkg::X2_W-1:0]          front_x2;

  // Per-step links; entry k feeds step k, entry k+1 is what step k leaves.
  logic [TERM_COUNT:0]                stage_valid;
  logic [tsmc_pkg::X2_W-1:0]          x2_link       [TERM_COUNT+1];
  logic [POW_W-1:0]                   sin_pow_link  [TERM_COUNT+1];
  logic [POW_W-1:0]                   cos_pow_link  [TERM_COUNT+1];
  logic signed [tsmc_pkg::ACC_W-1:0]  sin_acc_link  [TERM_COUNT+1];
  logic signed [tsmc_pkg::ACC_W-1:0]  cos_acc_link  [TERM_COUNT+1];
  logic [tsmc_pkg::TERM_W-1:0]        sin_term_link [TERM_COUNT+1];
  logic [tsmc_pkg::TERM_W-1:0]        cos_term_link [TERM_COUNT+1];

  // The whole pipeline advances together; it holds only when the output
  // buffer is full, so a stall never loses or repeats an item.
  assign in_stall = !advance;

  tsmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (in_valid),
    .angle     (angle),
    .out_valid (front_valid),
    .x         (front_x),
    .x2        (front_x2)
  );

  // Seed the series: sine power starts at x, cosine power at x^2,
  // sine sum at 0, cosine sum at 1, no pending terms.
  assign stage_valid[0]   = front_valid;
  assign x2_link[0]       = front_x2;
  assign sin_pow_link[0]  = POW_W'(front_x);
  assign cos_pow_link[0]  = POW_W'(front_x2);
  assign sin_acc_link[0]  = '0;
  assign cos_acc_link[0]  = $signed(tsmc_pkg::ACC_W'(tsmc_pkg::ONE));
  assign sin_term_link[0] = '0;
  assign cos_term_link[0] = '0;

  generate
    for (genvar k = 0; k < TERM_COUNT; k++) begin : g_step
      tsmc_step #(
        .K     (k),
        .POW_W (POW_W)
      ) u_step (
        .clk           (clk),
        .rst           (rst),
        .en            (advance),
        .in_valid      (stage_valid[k]),
        .x2            (x2_link[k]),
        .sin_pow       (sin_pow_link[k]),
        .cos_pow       (cos_pow_link[k]),
        .sin_acc       (sin_acc_link[k]),
        .cos_acc       (cos_acc_link[k]),
        .sin_term_prev (sin_term_link[k]),
        .cos_term_prev (cos_term_link[k]),
        .out_valid     (stage_valid[k+1]),
        .x2_out        (x2_link[k+1]),
        .sin_pow_out   (sin_pow_link[k+1]),
        .cos_pow_out   (cos_pow_link[k+1]),
        .sin_acc_out   (sin_acc_link[k+1]),
        .cos_acc_out   (cos_acc_link[k+1]),
        .sin_term      (sin_term_link[k+1]),
        .cos_term      (cos_term_link[k+1])
      );
    end
  endgenerate

  tsmc_tail #(
    .TERM_COUNT (TERM_COUNT)
  ) u_tail (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (stage_valid[TERM_COUNT]),
    .sin_acc      (sin_acc_link[TERM_COUNT]),
    .cos_acc      (cos_acc_link[TERM_COUNT]),
    .sin_term     (sin_term_link[TERM_COUNT]),
    .cos_term     (cos_term_link[TERM_COUNT]),
    .out_stall    (out_stall),
    .advance      (advance),
    .out_valid    (out_valid),
    .sine_value   (sine_value),
    .cosine_value (cosine_value),
    .difference   (difference)
  );

  // A full buffer means the output register holds a result too.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result in the output register");

  // While stalled, no item moves between pipeline stages.
  a_frozen_pipe: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(stage_valid))
    else $error("pipeline valid bits moved while stalled");

  // Saturated results never exceed one.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sine_value <= tsmc_pkg::ONE) && (cosine_value <= tsmc_pkg::ONE))
    else $error("sine or cosine above one");

  // The difference travels with the sine and cosine it came from.
  a_diff_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> difference == ($signed(tsmc_pkg::DIFF_W'(sine_value))
                                 - $signed(tsmc_pkg::DIFF_W'(cosine_value))))
    else $error("difference does not match sine and cosine");

endmodule

`default_nettype wire

[rtl/tsmc_fxmul.sv]
`default_nettype none

// Two-stage fixed-point multiply: (a*b + 2^(FRAC_W-1)) >> FRAC_W.
// Stage one forms 32-bit-sliced partial products, stage two adds and rounds.
module tsmc_fxmul #(
  parameter int A_W = 32,
  parameter int B_W = 32,
  parameter int R_W = 32
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [A_W-1:0] a,
  input  wire logic [B_W-1:0] b,
  output      logic [R_W-1:0] r
);

  localparam int P_W  = A_W + B_W;
  localparam int LO_W = (A_W > 32) ? 32 : A_W;
  localparam logic [P_W-1:0] HALF = P_W'(1) << (tsmc_pkg::FRAC_W - 1);

  logic [LO_W+B_W-1:0] lo_prod;
  logic [P_W-1:0]      prod_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_prod <= a[LO_W-1:0] * b;
    end
  end

  generate
    if (A_W > LO_W) begin : g_split
      logic [A_W-LO_W+B_W-1:0] hi_prod;

      always_ff @(posedge clk) begin
        if (en) begin
          hi_prod <= a[A_W-1:LO_W] * b;
        end
      end

      assign prod_sum = {hi_prod, {LO_W{1'b0}}} + P_W'(lo_prod) + HALF;
    end else begin : g_single
      assign prod_sum = P_W'(lo_prod) + HALF;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      r <= prod_sum[tsmc_pkg::FRAC_W +: R_W];
    end
  end

endmodule

`default_nettype wire

[rtl/tsmc_front.sv]
`default_nettype none

// Clamp the angle to pi/2, then square it.
module tsmc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [tsmc_pkg::ANGLE_W-1:0]  angle,
  output      logic                          out_valid,
  output      logic [tsmc_pkg::ANGLE_W-1:0]  x,
  output      logic [tsmc_pkg::X2_W-1:0]     x2
);

  logic [2:0]                       valid_pipe;
  logic [tsmc_pkg::ANGLE_W-1:0]     x_clamp;
  logic [tsmc_pkg::ANGLE_W-1:0]     x_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_clamp <= (angle > tsmc_pkg::HALF_PI) ? tsmc_pkg::HALF_PI : angle;
      x_mid   <= x_clamp;
      x       <= x_mid;
    end
  end

  tsmc_fxmul #(
    .A_W (tsmc_pkg::ANGLE_W),
    .B_W (tsmc_pkg::ANGLE_W),
    .R_W (tsmc_pkg::X2_W)
  ) u_square (
    .clk (clk),
    .en  (en),
    .a   (x_clamp),
    .b   (x_clamp),
    .r   (x2)
  );

  assign out_valid = valid_pipe[2];

endmodule

`default_nettype wire

[rtl/tsmc_step.sv]
`default_nettype none

// One series step: fold in the previous step's terms, form this step's sine
// term and advance its power by x^2; steps past 0 do the same for cosine.
module tsmc_step #(
  parameter int K     = 0,
  parameter int POW_W = 44
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [tsmc_pkg::X2_W-1:0]          x2,
  input  wire logic [POW_W-1:0]                   sin_pow,
  input  wire logic [POW_W-1:0]                   cos_pow,
  input  wire logic signed [tsmc_pkg::ACC_W-1:0]  sin_acc,
  input  wire logic signed [tsmc_pkg::ACC_W-1:0]  cos_acc,
  input  wire logic [tsmc_pkg::TERM_W-1:0]        sin_term_prev,
  input  wire logic [tsmc_pkg::TERM_W-1:0]        cos_term_prev,
  output      logic                               out_valid,
  output      logic [tsmc_pkg::X2_W-1:0]          x2_out,
  output      logic [POW_W-1:0]                   sin_pow_out,
  output      logic [POW_W-1:0]                   cos_pow_out,
  output      logic signed [tsmc_pkg::ACC_W-1:0]  sin_acc_out,
  output      logic signed [tsmc_pkg::ACC_W-1:0]  cos_acc_out,
  output      logic [tsmc_pkg::TERM_W-1:0]        sin_term,
  output      logic [tsmc_pkg::TERM_W-1:0]        cos_term
);

  // Terms alternate in sign; the previous step had index K-1.
  localparam bit PREV_SUB = (K % 2) == 0;
  localparam logic [tsmc_pkg::RECIP_W-1:0] SIN_RECIP = tsmc_pkg::RECIP[2*K+1];

  logic [1:0]                        valid_pipe;
  logic [tsmc_pkg::X2_W-1:0]         x2_mid;
  logic signed [tsmc_pkg::ACC_W-1:0] sin_acc_mid;
  logic signed [tsmc_pkg::ACC_W-1:0] cos_acc_mid;
  logic signed [tsmc_pkg::ACC_W-1:0] sin_add;
  logic signed [tsmc_pkg::ACC_W-1:0] cos_add;

  assign sin_add = $signed(tsmc_pkg::ACC_W'(sin_term_prev));
  assign cos_add = $signed(tsmc_pkg::ACC_W'(cos_term_prev));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_mid      <= x2;
      x2_out      <= x2_mid;
      sin_acc_mid <= PREV_SUB ? sin_acc - sin_add : sin_acc + sin_add;
      cos_acc_mid <= PREV_SUB ? cos_acc - cos_add : cos_acc + cos_add;
      sin_acc_out <= sin_acc_mid;
      cos_acc_out <= cos_acc_mid;
    end
  end

  tsmc_fxmul #(
    .A_W (POW_W),
    .B_W (tsmc_pkg::X2_W),
    .R_W (POW_W)
  ) u_sin_pow (
    .clk (clk),
    .en  (en),
    .a   (sin_pow),
    .b   (x2),
    .r   (sin_pow_out)
  );

  tsmc_fxmul #(
    .A_W (POW_W),
    .B_W (tsmc_pkg::RECIP_W),
    .R_W (tsmc_pkg::TERM_W)
  ) u_sin_term (
    .clk (clk),
    .en  (en),
    .a   (sin_pow),
    .b   (SIN_RECIP),
    .r   (sin_term)
  );

  generate
    if (K == 0) begin : g_cos_first
      // The cosine series opens with the constant 1: no term here, and
      // the cosine power (x^2) passes through unchanged.
      logic [POW_W-1:0] cos_pow_mid;

      always_ff @(posedge clk) begin
        if (en) begin
          cos_pow_mid <= cos_pow;
          cos_pow_out <= cos_pow_mid;
        end
      end

      assign cos_term = '0;
    end else begin : g_cos_step
      localparam logic [tsmc_pkg::RECIP_W-1:0] COS_RECIP = tsmc_pkg::RECIP[2*K];

      tsmc_fxmul #(
        .A_W (POW_W),
        .B_W (tsmc_pkg::X2_W),
        .R_W (POW_W)
      ) u_cos_pow (
        .clk (clk),
        .en  (en),
        .a   (cos_pow),
        .b   (x2),
        .r   (cos_pow_out)
      );

      tsmc_fxmul #(
        .A_W (POW_W),
        .B_W (tsmc_pkg::RECIP_W),
        .R_W (tsmc_pkg::TERM_W)
      ) u_cos_term (
        .clk (clk),
        .en  (en),
        .a   (cos_pow),
        .b   (COS_RECIP),
        .r   (cos_term)
      );
    end
  endgenerate

  assign out_valid = valid_pipe[1];

endmodule

`default_nettype wire

[rtl/tsmc_tail.sv]
`default_nettype none

// Fold in the last terms, saturate both sums to [0, 1], form the difference
// and hold the result in a two-entry output buffer (output register + skid).
module tsmc_tail #(
  parameter int TERM_COUNT = tsmc_pkg::TERM_COUNT_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic signed [tsmc_pkg::ACC_W-1:0]  sin_acc,
  input  wire logic signed [tsmc_pkg::ACC_W-1:0]  cos_acc,
  input  wire logic [tsmc_pkg::TERM_W-1:0]        sin_term,
  input  wire logic [tsmc_pkg::TERM_W-1:0]        cos_term,
  input  wire logic                               out_stall,
  output      logic                               advance,
  output      logic                               out_valid,
  output      logic [tsmc_pkg::RESULT_W-1:0]      sine_value,
  output      logic [tsmc_pkg::RESULT_W-1:0]      cosine_value,
  output      logic signed [tsmc_pkg::DIFF_W-1:0] difference
);

  localparam bit LAST_SUB = ((TERM_COUNT - 1) % 2) == 1;

  function automatic logic [tsmc_pkg::RESULT_W-1:0] sat_unit(
    input logic signed [tsmc_pkg::ACC_W-1:0] v
  );
    logic [tsmc_pkg::RESULT_W-1:0] res;
    priority if (v < 0) begin
      res = '0;
    end else if (v > $signed(tsmc_pkg::ACC_W'(tsmc_pkg::ONE))) begin
      res = tsmc_pkg::ONE;
    end else begin
      res = v[tsmc_pkg::RESULT_W-1:0];
    end
    return res;
  endfunction

  logic                               sum_valid;
  logic signed [tsmc_pkg::ACC_W-1:0]  sin_sum;
  logic signed [tsmc_pkg::ACC_W-1:0]  cos_sum;
  logic signed [tsmc_pkg::ACC_W-1:0]  sin_add;
  logic signed [tsmc_pkg::ACC_W-1:0]  cos_add;
  logic [tsmc_pkg::RESULT_W-1:0]      sin_sat;
  logic [tsmc_pkg::RESULT_W-1:0]      cos_sat;
  logic signed [tsmc_pkg::DIFF_W-1:0] diff_calc;
  logic                               push;
  logic                               skid_valid;
  logic [tsmc_pkg::RESULT_W-1:0]      skid_sine;
  logic [tsmc_pkg::RESULT_W-1:0]      skid_cosine;
  logic signed [tsmc_pkg::DIFF_W-1:0] skid_diff;

  assign sin_add = $signed(tsmc_pkg::ACC_W'(sin_term));
  assign cos_add = $signed(tsmc_pkg::ACC_W'(cos_term));

  assign advance = !skid_valid;
  assign push    = advance && sum_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (advance) begin
      sum_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sin_sum <= LAST_SUB ? sin_acc - sin_add : sin_acc + sin_add;
      cos_sum <= LAST_SUB ? cos_acc - cos_add : cos_acc + cos_add;
    end
  end

  assign sin_sat   = sat_unit(sin_sum);
  assign cos_sat   = sat_unit(cos_sum);
  assign diff_calc = $signed(tsmc_pkg::DIFF_W'(sin_sat)) - $signed(tsmc_pkg::DIFF_W'(cos_sat));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        sine_value   <= skid_sine;
        cosine_value <= skid_cosine;
        difference   <= skid_diff;
      end else begin
        sine_value   <= sin_sat;
        cosine_value <= cos_sat;
        difference   <= diff_calc;
      end
    end else if (push) begin
      skid_sine   <= sin_sat;
      skid_cosine <= cos_sat;
      skid_diff   <= diff_calc;
    end
  end

endmodule

`default_nettype wire
